// File: rtl/tspdp_pkg.sv
// Package for the bitmask DP travelling salesman solver.
// Holds request/response types, field widths, register index and cost constants.
// No dependencies.
package tspdp_pkg;

   localparam int MAX_CITIES_DEF = 16;
   localparam int DIST_BITS_DEF  = 20;
   localparam int CITY_BITS      = 4;
   localparam int DIST_IN_BITS   = 20;
   localparam int COST_BITS      = 24;
   localparam int PATH_BITS      = 25;
   localparam int CFG_BITS       = 5;

   localparam logic [CFG_BITS-1:0]  CITY_COUNT_RESET = 5'd16;
   localparam logic [COST_BITS-1:0] COST_MAX         = '1;
   localparam logic [PATH_BITS-1:0] COST_INF         = '1;

   // register index, taken from paddr[2]
   localparam logic CSR_CITY_COUNT = 1'b0;

   typedef struct packed {
      logic [CITY_BITS-1:0]    from_city;
      logic [CITY_BITS-1:0]    to_city;
      logic [DIST_IN_BITS-1:0] distance;
      logic                    last_entry;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] tour_cost;
      logic                 no_tour;
   } rsp_type;

endpackage

// File: rtl/tspdp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tspdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/tsp_bitmask_dp_solver.sv
// A matrix entry is accepted only while idle. The last entry starts a run that clears the
// subset table for every mask up to the full set, then per odd subset and city tries each
// next city not yet in the subset, then closes the tour back to city 0 from cities 1 to n-1.
// One result strobe follows; busy stays high for the whole run (one shared adder/compare).
// Reset clears the sequencer, the strobe and city_count (to 16); the edge table
// and the subset table hold no reset value. The receiver cannot stall.
module tsp_bitmask_dp_solver #(
   parameter int MAX_CITIES = tspdp_pkg::MAX_CITIES_DEF,
   parameter int DIST_BITS  = tspdp_pkg::DIST_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tspdp_pkg::req_type  req_data,
   output logic                rsp_valid,
   output tspdp_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int CurBits      = $clog2(MAX_CITIES);
   localparam int CntBits      = CurBits + 1;
   localparam int MaskBits     = MAX_CITIES;
   localparam int SubAddrBits  = MaskBits + CurBits;
   localparam int EdgeAddrBits = 2 * CurBits;
   localparam int CostBits     = tspdp_pkg::COST_BITS;
   localparam int PathBits     = tspdp_pkg::PATH_BITS;
   localparam int CfgBits      = tspdp_pkg::CFG_BITS;
   localparam int SumBits      = ((DIST_BITS > CostBits) ? DIST_BITS : CostBits) + 1;
   localparam int DistWide     = DIST_BITS + tspdp_pkg::DIST_IN_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_HERE_RD,
      ST_HERE_CHK,
      ST_NXT_RD,
      ST_NXT_CMP,
      ST_FIN_RD,
      ST_FIN_CMP
   } state_type;

   state_type             state_ff, state_in;
   logic [CfgBits-1:0]    city_count_ff, city_count_in;
   logic [CntBits-1:0]    n_ff, n_in;
   logic [MaskBits-1:0]   full_ff, full_in;
   logic [MaskBits-1:0]   mask_ff, mask_in;
   logic [CurBits-1:0]    cur_ff, cur_in;
   logic [CurBits-1:0]    nxt_ff, nxt_in;
   logic [CostBits-1:0]   here_ff, here_in;
   logic [PathBits-1:0]   best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tspdp_pkg::rsp_type    rsp_ff, rsp_in;

   logic                  req_acc;
   logic                  csr_wr;
   logic [CntBits-1:0]    n_clamp;

   // edge table
   logic                  edge_we;
   logic [EdgeAddrBits-1:0] edge_waddr, edge_raddr;
   logic [DIST_BITS-1:0]  edge_wdata, edge_rdata;
   logic [DistWide-1:0]   dist_wide;

   // subset table
   logic                  sub_we;
   logic [SubAddrBits-1:0] sub_waddr, sub_raddr;
   logic [PathBits-1:0]   sub_wdata, sub_rdata;

   // shared add / compare unit
   logic [CostBits-1:0]   add_a;
   logic [PathBits-1:0]   cmp_b;
   logic [SumBits-1:0]    sum;
   logic [CostBits-1:0]   cand;
   logic                  better;
   logic                  edge_nz;

   logic [MaskBits-1:0]   nxt_bit, nm;
   logic                  cur_last, nxt_last, mask_last, adv_cur;

   assign req_acc = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign csr_wr  = psel && penable && pwrite && (paddr[2] == tspdp_pkg::CSR_CITY_COUNT);
   assign pready  = 1'b1;
   assign prdata  = (paddr[2] == tspdp_pkg::CSR_CITY_COUNT) ?
                    {{(32-CfgBits){1'b0}}, city_count_ff} : 32'd0;

   assign n_clamp = (city_count_ff < CfgBits'(2)) ? CntBits'(2) :
                    (city_count_ff > CfgBits'(MAX_CITIES)) ? CntBits'(MAX_CITIES) :
                    CntBits'(city_count_ff);

   assign dist_wide  = {{DIST_BITS{1'b0}}, req_data.distance};
   assign edge_wdata = dist_wide[DIST_BITS-1:0];
   assign edge_we    = req_acc &&
                       ({1'b0, req_data.from_city} < CfgBits'(MAX_CITIES)) &&
                       ({1'b0, req_data.to_city} < CfgBits'(MAX_CITIES));
   assign edge_waddr = {req_data.from_city[CurBits-1:0], req_data.to_city[CurBits-1:0]};

   assign nxt_bit   = MaskBits'(1) << nxt_ff;
   assign nm        = mask_ff | nxt_bit;
   assign cur_last  = ({1'b0, cur_ff} + CntBits'(1)) == n_ff;
   assign nxt_last  = ({1'b0, nxt_ff} + CntBits'(1)) == n_ff;
   assign mask_last = (mask_ff == full_ff);

   assign add_a   = (state_ff == ST_FIN_CMP) ? sub_rdata[CostBits-1:0] : here_ff;
   assign cmp_b   = (state_ff == ST_FIN_CMP) ? best_ff : sub_rdata;
   assign sum     = SumBits'(add_a) + SumBits'(edge_rdata);
   assign cand    = (sum > SumBits'(tspdp_pkg::COST_MAX)) ? tspdp_pkg::COST_MAX :
                    sum[CostBits-1:0];
   assign better  = {1'b0, cand} < cmp_b;
   assign edge_nz = (edge_rdata != '0);

   always_comb begin
      sub_we     = 1'b0;
      sub_waddr  = {mask_ff, cur_ff};
      sub_wdata  = tspdp_pkg::COST_INF;
      sub_raddr  = {mask_ff, cur_ff};
      edge_raddr = {cur_ff, nxt_ff};
      case (state_ff)
         ST_CLEAR: begin
            sub_we = 1'b1;
         end
         ST_SEED: begin
            sub_we    = 1'b1;
            sub_waddr = {MaskBits'(1), CurBits'(0)};
            sub_wdata = '0;
         end
         ST_NXT_RD: begin
            sub_raddr = {nm, nxt_ff};
         end
         ST_NXT_CMP: begin
            sub_we    = edge_nz && better;
            sub_waddr = {nm, nxt_ff};
            sub_wdata = {1'b0, cand};
         end
         ST_FIN_RD: begin
            sub_raddr  = {full_ff, cur_ff};
            edge_raddr = {cur_ff, CurBits'(0)};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      city_count_in = csr_wr ? pwdata[CfgBits-1:0] : city_count_ff;
      n_in          = n_ff;
      full_in       = full_ff;
      mask_in       = mask_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      here_in       = here_ff;
      best_in       = best_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      adv_cur       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.last_entry) begin
               n_in     = n_clamp;
               full_in  = ~({MaskBits{1'b1}} << n_clamp);
               mask_in  = '0;
               cur_in   = '0;
               best_in  = tspdp_pkg::COST_INF;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cur_in = cur_ff + CurBits'(1);
            if (cur_ff == '1) begin
               if (mask_last) begin
                  state_in = ST_SEED;
               end else begin
                  mask_in = mask_ff + MaskBits'(1);
               end
            end
         end
         ST_SEED: begin
            mask_in  = MaskBits'(1);
            cur_in   = '0;
            state_in = ST_HERE_RD;
         end
         ST_HERE_RD: begin
            state_in = ST_HERE_CHK;
         end
         ST_HERE_CHK: begin
            if (sub_rdata == tspdp_pkg::COST_INF) begin
               adv_cur = 1'b1;
            end else begin
               here_in  = sub_rdata[CostBits-1:0];
               nxt_in   = '0;
               state_in = ST_NXT_RD;
            end
         end
         ST_NXT_RD: begin
            if ((mask_ff & nxt_bit) != '0) begin
               if (nxt_last) begin
                  adv_cur = 1'b1;
               end else begin
                  nxt_in = nxt_ff + CurBits'(1);
               end
            end else begin
               state_in = ST_NXT_CMP;
            end
         end
         ST_NXT_CMP: begin
            if (nxt_last) begin
               adv_cur = 1'b1;
            end else begin
               nxt_in   = nxt_ff + CurBits'(1);
               state_in = ST_NXT_RD;
            end
         end
         ST_FIN_RD: begin
            state_in = ST_FIN_CMP;
         end
         ST_FIN_CMP: begin
            if ((sub_rdata != tspdp_pkg::COST_INF) && edge_nz && better) begin
               best_in = {1'b0, cand};
            end
            if (cur_last) begin
               rsp_valid_in = 1'b1;
               if (best_in == tspdp_pkg::COST_INF) begin
                  rsp_in.tour_cost = '0;
                  rsp_in.no_tour   = 1'b1;
               end else begin
                  rsp_in.tour_cost = best_in[CostBits-1:0];
                  rsp_in.no_tour   = 1'b0;
               end
               state_in = ST_IDLE;
            end else begin
               cur_in   = cur_ff + CurBits'(1);
               state_in = ST_FIN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (adv_cur) begin
         if (cur_last) begin
            if (mask_last) begin
               cur_in   = CurBits'(1);
               state_in = ST_FIN_RD;
            end else begin
               mask_in  = mask_ff + MaskBits'(2);
               cur_in   = '0;
               state_in = ST_HERE_RD;
            end
         end else begin
            cur_in   = cur_ff + CurBits'(1);
            state_in = ST_HERE_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         city_count_ff <= tspdp_pkg::CITY_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         city_count_ff <= city_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff    <= n_in;
      full_ff <= full_in;
      mask_ff <= mask_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      here_ff <= here_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   tspdp_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (1 << EdgeAddrBits)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   tspdp_ram #(
      .WIDTH (PathBits),
      .DEPTH (1 << SubAddrBits)
   ) u_subset_ram (
      .clock (clock),
      .we    (sub_we),
      .waddr (sub_waddr),
      .wdata (sub_wdata),
      .raddr (sub_raddr),
      .rdata (sub_rdata)
   );

endmodule

// File: bench/tb_tsp_bitmask_dp_solver.sv
// Testbench for tsp_bitmask_dp_solver: loads distance matrices and checks each tour result
// against an in-bench Held-Karp solver. Configuration goes through the APB port.
// Depends on tspdp_pkg and the solver RTL only.
module tb_tsp_bitmask_dp_solver;

   typedef logic [tspdp_pkg::DIST_IN_BITS-1:0] dist_type;
   typedef logic [tspdp_pkg::PATH_BITS-1:0]    path_type;
   typedef logic [tspdp_pkg::PATH_BITS:0]      wide_type;

   localparam dist_type DIST_TOP = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tspdp_pkg::req_type req_data = '0;
   logic rsp_valid;
   tspdp_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   tsp_bitmask_dp_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   tspdp_pkg::req_type pending[$];
   tspdp_pkg::rsp_type tours_due[$];
   dist_type arc_cost [tspdp_pkg::MAX_CITIES_DEF][tspdp_pkg::MAX_CITIES_DEF];
   bit arc_loaded [tspdp_pkg::MAX_CITIES_DEF][tspdp_pkg::MAX_CITIES_DEF];
   logic [tspdp_pkg::CFG_BITS-1:0] cfg_cities = tspdp_pkg::CITY_COUNT_RESET;
   int idle_pct = 0;
   int plan_cities = tspdp_pkg::MAX_CITIES_DEF;
   int cycle_budget = 200;
   int cycles = 0;
   int mismatches = 0;
   int entries_planned = 0;
   int tours_planned = 0;
   int entries_seen = 0;
   int tours_seen = 0;
   int no_tour_seen = 0;
   int writes_done = 0;
   int widest_solve = 0;
   logic req_taken = 1'b0;

   function automatic int used_cities(input logic [tspdp_pkg::CFG_BITS-1:0] c);
      if (c < 2) return 2;
      if (c > tspdp_pkg::MAX_CITIES_DEF) return tspdp_pkg::MAX_CITIES_DEF;
      return c;
   endfunction

   function automatic path_type path_add(input path_type a, input dist_type b);
      wide_type s;
      s = wide_type'(a) + wide_type'(b);
      if (s > wide_type'(tspdp_pkg::COST_MAX)) return path_type'(tspdp_pkg::COST_MAX);
      return s[tspdp_pkg::PATH_BITS-1:0];
   endfunction

   // Held-Karp from city 0 over the first n cities
   function automatic tspdp_pkg::rsp_type cheapest_tour(
      input logic [tspdp_pkg::CFG_BITS-1:0] cfg);
      int n, full, nm;
      path_type path[];
      path_type here, cand, best;
      dist_type e;
      tspdp_pkg::rsp_type r;
      n = used_cities(cfg);
      full = (1 << n) - 1;
      path = new[(full + 1) * n];
      foreach (path[i]) path[i] = tspdp_pkg::COST_INF;
      path[n] = '0;
      for (int m = 1; m <= full; m += 2) begin
         for (int c = 0; c < n; c++) begin
            here = path[m * n + c];
            if (here != tspdp_pkg::COST_INF) begin
               for (int x = 0; x < n; x++) begin
                  e = arc_cost[c][x];
                  if (((m >> x) & 1) == 0 && e != 0) begin
                     nm = m | (1 << x);
                     cand = path_add(here, e);
                     if (cand < path[nm * n + x]) path[nm * n + x] = cand;
                  end
               end
            end
         end
      end
      best = tspdp_pkg::COST_INF;
      for (int c = 1; c < n; c++) begin
         here = path[full * n + c];
         e = arc_cost[c][0];
         if (here != tspdp_pkg::COST_INF && e != 0) begin
            cand = path_add(here, e);
            if (cand < best) best = cand;
         end
      end
      r.no_tour = (best == tspdp_pkg::COST_INF);
      r.tour_cost = r.no_tour ? '0 : best[tspdp_pkg::COST_BITS-1:0];
      return r;
   endfunction

   function automatic int solve_cycles(input int n);
      return (1 << n) * 16 + (1 << (n - 1)) * n * (2 + 2 * n) + 2 * n + 32;
   endfunction

   function automatic dist_type pick_distance(input int zero_pct);
      dist_type d;
      int roll;
      roll = $urandom_range(99);
      if (roll < zero_pct) return '0;
      roll = $urandom_range(7);
      if (roll == 0) d = DIST_TOP;
      else if (roll < 3) d = dist_type'($urandom_range(15, 1));
      else d = dist_type'($urandom);
      return d;
   endfunction

   task automatic send_entry(input int f, input int t, input dist_type d, input logic last);
      tspdp_pkg::req_type r;
      r.from_city = f[tspdp_pkg::CITY_BITS-1:0];
      r.to_city = t[tspdp_pkg::CITY_BITS-1:0];
      r.distance = d;
      r.last_entry = last;
      pending.push_back(r);
      arc_loaded[f][t] = 1'b1;
      entries_planned++;
      cycle_budget += 12;
      if (last) begin
         tours_planned++;
         cycle_budget += solve_cycles(plan_cities);
         if (plan_cities > widest_solve) widest_solve = plan_cities;
      end
   endtask

   task automatic plan_tour_problem(input int n, input int zero_pct);
      int f, t;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!arc_loaded[i][j]) send_entry(i, j, pick_distance(zero_pct), 1'b0);
      repeat ($urandom_range(n)) begin
         if ($urandom_range(9) == 0) begin
            f = $urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1);
            t = $urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1);
         end else begin
            f = $urandom_range(n - 1);
            t = $urandom_range(n - 1);
         end
         send_entry(f, t, pick_distance(zero_pct), 1'b0);
      end
      if ($urandom_range(5) == 0) begin
         f = $urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1);
         t = $urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1);
      end else begin
         f = $urandom_range(n - 1);
         t = $urandom_range(n - 1);
      end
      send_entry(f, t, pick_distance(zero_pct), 1'b1);
   endtask

   task automatic program_city_count(input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {tspdp_pkg::CSR_CITY_COUNT, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[tspdp_pkg::CFG_BITS-1:0] !== value[tspdp_pkg::CFG_BITS-1:0]) begin
         mismatches++;
         $display("%0t: city_count read-back expected %0d got %0d", $time,
                  value[tspdp_pkg::CFG_BITS-1:0], prdata[tspdp_pkg::CFG_BITS-1:0]);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      plan_cities = used_cities(value[tspdp_pkg::CFG_BITS-1:0]);
      writes_done++;
      cycle_budget += 20;
   endtask

   task automatic drain();
      while (pending.size() != 0 || start) @(posedge clock);
      while (tours_due.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      cycle_budget += 20;
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!start || req_taken)) begin
         if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : watch
      tspdp_pkg::rsp_type due;
      cycles++;
      req_taken <= !reset && start && !busy;
      if (reset) begin
         cfg_cities = tspdp_pkg::CITY_COUNT_RESET;
      end else begin
         if (rsp_valid) begin
            if (tours_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result cost %0d no_tour %0b", $time,
                        rsp_data.tour_cost, rsp_data.no_tour);
            end else begin
               due = tours_due.pop_front();
               tours_seen++;
               if (due.no_tour) no_tour_seen++;
               if (rsp_data.tour_cost !== due.tour_cost) begin
                  mismatches++;
                  $display("%0t: tour_cost expected %0d got %0d", $time,
                           due.tour_cost, rsp_data.tour_cost);
               end
               if (rsp_data.no_tour !== due.no_tour) begin
                  mismatches++;
                  $display("%0t: no_tour expected %0b got %0b", $time,
                           due.no_tour, rsp_data.no_tour);
               end
            end
         end
         if (start && !busy) begin
            arc_cost[req_data.from_city][req_data.to_city] = req_data.distance;
            entries_seen++;
            if (req_data.last_entry) tours_due.push_back(cheapest_tour(cfg_cities));
         end
         if (psel && penable && pwrite && pready && paddr[2] == tspdp_pkg::CSR_CITY_COUNT)
            cfg_cities = pwdata[tspdp_pkg::CFG_BITS-1:0];
      end
      if (cycles > 4 * cycle_budget + 2000) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int count_seq[16];
      int idle_seq[3];
      int zero_seq[3];
      int ph, n;
      count_seq = '{31, 3, 4, 1, 6, 16, 8, 5, 0, 10, 17, 7, 2, 9, 5, 3};
      idle_seq = '{0, 74, 21};
      zero_seq = '{0, 10, 40};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: two cities, extremes, missing return arc, unused entries
      idle_pct = 0;
      program_city_count(2);
      send_entry(0, 0, DIST_TOP, 1'b0);
      send_entry(1, 1, '0, 1'b0);
      send_entry(0, 1, DIST_TOP, 1'b0);
      send_entry(1, 0, DIST_TOP, 1'b1);
      send_entry(1, 0, '0, 1'b1);
      send_entry(1, 0, dist_type'(1), 1'b1);
      send_entry(15, 15, DIST_TOP, 1'b0);
      send_entry(15, 0, DIST_TOP, 1'b0);
      send_entry(0, 15, DIST_TOP, 1'b1);
      send_entry(0, 1, dist_type'(1), 1'b1);
      drain();
      program_city_count(0);
      send_entry(0, 1, dist_type'(7), 1'b1);
      drain();
      // three cities, one-way ring only
      program_city_count(3);
      send_entry(0, 1, dist_type'(5), 1'b0);
      send_entry(1, 2, dist_type'(6), 1'b0);
      send_entry(2, 0, dist_type'(7), 1'b0);
      send_entry(1, 0, '0, 1'b0);
      send_entry(2, 1, '0, 1'b0);
      send_entry(2, 2, DIST_TOP, 1'b0);
      send_entry(0, 2, '0, 1'b1);
      send_entry(0, 2, dist_type'(3), 1'b1);
      drain();

      ph = 0;
      while (entries_planned < 100) begin
         idle_pct = idle_seq[ph % 3];
         program_city_count(count_seq[ph % 16]);
         n = plan_cities;
         if (n == tspdp_pkg::MAX_CITIES_DEF) begin
            repeat (12)
               send_entry($urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1),
                          $urandom_range(tspdp_pkg::MAX_CITIES_DEF - 1),
                          pick_distance(20), 1'b0);
         end else begin
            repeat (n >= 8 ? 1 : $urandom_range(5, 2))
               plan_tour_problem(n, zero_seq[$urandom_range(2)]);
         end
         drain();
         ph++;
      end

      $display("Run covered %0d matrix entries and %0d tours (%0d with no tour).",
               entries_seen, tours_seen, no_tour_seen);
      $display("City count written %0d times, largest problem solved: %0d cities.",
               writes_done, widest_solve);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tspdp_pkg.sv
rtl/tspdp_ram.sv
rtl/tsp_bitmask_dp_solver.sv
bench/tb_tsp_bitmask_dp_solver.sv
